>>> sv/obbp_pkg.sv
// obbp_pkg: shared types, constants and helpers of the one-bit branch predictor.
// No dependencies; compile first.
`timescale 1ns / 1ps

package obbp_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int ADDR_W          = 64;
	localparam int CNT_W           = 32;
	localparam int FOLD_W          = 15;   // index_bits tops out at 15
	localparam int RECIP_SHIFT     = 16;
	localparam int DATA_W          = 32;
	localparam int PADDR_W         = 3;

	localparam logic [3:0] INDEX_BITS_RST = 4'd10;
	localparam logic [5:0] FOLD_SHIFT_RST = 6'd12;

	typedef enum logic {
		REG_INDEX_BITS = 1'b0,
		REG_FOLD_SHIFT = 1'b1
	} reg_t;

	typedef enum logic [1:0] {
		REQ_PREDICT     = 2'd0,
		REQ_UPDATE      = 2'd1,
		REQ_CLEAR_STATS = 2'd2,
		REQ_CLEAR_ALL   = 2'd3
	} req_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;  // latch request, fold and mask address
		logic divide;   // reciprocal multiply for the depth reduction
		logic lookup;   // finish reduction, issue table read
		logic commit;   // update counters/table, load result word
		logic sweep;    // write one zero entry of the table
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_all;
		logic sweep_last;
	} sts_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + CNT_W'(1);
	endfunction

endpackage

>>> sv/obbp_ifs.sv
// obbp_req_if / obbp_rsp_if: valid/ready channels of the branch predictor.
// Depends on obbp_pkg.
`timescale 1ns / 1ps

interface obbp_req_if;
	import obbp_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [ADDR_W-1:0] branch_address;
	logic              actual_taken;

	modport source(output valid, req_type, branch_address, actual_taken, input ready);
	modport sink(input valid, req_type, branch_address, actual_taken, output ready);
endinterface

interface obbp_rsp_if;
	import obbp_pkg::*;
	logic             valid;
	logic             ready;
	logic             predicted_taken;
	logic [CNT_W-1:0] total_count;
	logic [CNT_W-1:0] taken_count;
	logic [CNT_W-1:0] correct_count;
	logic [CNT_W-1:0] correct_taken_count;
	logic [CNT_W-1:0] correct_not_taken_count;

	modport source(output valid, predicted_taken, total_count, taken_count, correct_count,
		correct_taken_count, correct_not_taken_count, input ready);
	modport sink(input valid, predicted_taken, total_count, taken_count, correct_count,
		correct_taken_count, correct_not_taken_count, output ready);
endinterface

>>> sv/one_bit_branch_predictor.sv
// one_bit_branch_predictor: top level, APB register file, FSM, datapath and table RAM.
// Depends on obbp_pkg, obbp_ifs, obbp_ram, obbp_ctrl, obbp_dp.
`timescale 1ns / 1ps

// Channel  Dir  Handshake      Word
// req      in   valid/ready    req_type, branch_address, actual_taken
// rsp      out  valid/ready    predicted_taken + five 32-bit statistics counters
// apb      in   psel/penable   index_bits (0x0), fold_shift (0x4)
//
// A request runs through capture and hash, reciprocal multiply, modulo fix-up with
// table read, and commit. The result is valid after the commit edge. The modulo by
// TABLE_DEPTH and the registered table read set these steps; one word is in flight
// at a time. Clear-all adds a sweep of the whole table, one table entry per cycle.
// After reset the same sweep runs before the first request is taken.
// A stalled rsp word holds; a new request is still taken and waits in commit.

module one_bit_branch_predictor #(
	parameter int TABLE_DEPTH = obbp_pkg::TABLE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	obbp_req_if.sink                       req,
	obbp_rsp_if.source                     rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [obbp_pkg::PADDR_W-1:0]   paddr,
	input  logic [obbp_pkg::DATA_W-1:0]    pwdata,
	output logic [obbp_pkg::DATA_W-1:0]    prdata,
	output logic                           pready
);
	import obbp_pkg::*;

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [3:0] index_bits_q;
	logic [5:0] fold_shift_q;
	logic       cfg_wr;
	reg_t       cfg_sel;

	cmd_t cmd;
	sts_t sts;

	logic          ram_we, ram_re, ram_wdata, ram_rdata;
	logic [IW-1:0] ram_waddr, ram_raddr;

	// ---- configuration registers ----
	assign pready  = 1'b1;
	assign cfg_sel = reg_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q <= INDEX_BITS_RST;
			fold_shift_q <= FOLD_SHIFT_RST;
		end else if (cfg_wr) begin
			case (cfg_sel)
				REG_INDEX_BITS: index_bits_q <= pwdata[3:0];
				REG_FOLD_SHIFT: fold_shift_q <= pwdata[5:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			REG_INDEX_BITS: prdata = DATA_W'(index_bits_q);
			REG_FOLD_SHIFT: prdata = DATA_W'(fold_shift_q);
			default:        prdata = '0;
		endcase
	end

	// ---- sequencer ----
	obbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// ---- datapath ----
	obbp_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.cmd                     (cmd),
		.sts                     (sts),
		.req_type                (req.req_type),
		.branch_address          (req.branch_address),
		.actual_taken            (req.actual_taken),
		.index_bits              (index_bits_q),
		.fold_shift              (fold_shift_q),
		.ram_we                  (ram_we),
		.ram_waddr               (ram_waddr),
		.ram_wdata               (ram_wdata),
		.ram_re                  (ram_re),
		.ram_raddr               (ram_raddr),
		.ram_rdata               (ram_rdata),
		.predicted_taken         (rsp.predicted_taken),
		.total_count             (rsp.total_count),
		.taken_count             (rsp.taken_count),
		.correct_count           (rsp.correct_count),
		.correct_taken_count     (rsp.correct_taken_count),
		.correct_not_taken_count (rsp.correct_not_taken_count)
	);

	// ---- direction table ----
	obbp_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ---- checks ----
	// no request is taken while the table is being swept
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> !req.ready)
		else $error("request accepted during table sweep");

	// one word in flight: acceptance closes the input for the next cycle
	a_single_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("second request accepted while one is in flight");

	// a new result only appears after a commit
	a_valid_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(cmd.commit))
		else $error("result valid without commit");

	// table reads and writes never collide
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("table read and write in the same cycle");

endmodule

>>> sv/obbp_ram.sv
// obbp_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module obbp_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/obbp_ctrl.sv
// obbp_ctrl: sequencing FSM of the branch predictor (one word in flight).
// Depends on obbp_pkg.
`timescale 1ns / 1ps

module obbp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output obbp_pkg::cmd_t cmd,
	input  obbp_pkg::sts_t sts
);
	import obbp_pkg::*;

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_FOLD   = 5'b00100,
		ST_REDUCE = 5'b01000,
		ST_COMMIT = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_FOLD;
				end
			end
			ST_FOLD: begin
				cmd.divide = 1'b1;
				state_d    = ST_REDUCE;
			end
			ST_REDUCE: begin
				cmd.lookup = 1'b1;
				state_d    = ST_COMMIT;
			end
			ST_COMMIT: begin
				// wait for the result register to drain
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = sts.clear_all ? ST_CLEAR : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/obbp_dp.sv
// obbp_dp: address hash, depth reduction, statistics counters and table access.
// Depends on obbp_pkg; drives the table RAM ports.
`timescale 1ns / 1ps

module obbp_dp #(
	parameter int TABLE_DEPTH = obbp_pkg::TABLE_DEPTH_DEF,
	localparam int IW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  obbp_pkg::cmd_t                cmd,
	output obbp_pkg::sts_t                sts,
	input  logic [1:0]                    req_type,
	input  logic [obbp_pkg::ADDR_W-1:0]   branch_address,
	input  logic                          actual_taken,
	input  logic [3:0]                    index_bits,
	input  logic [5:0]                    fold_shift,
	output logic                          ram_we,
	output logic [IW-1:0]                 ram_waddr,
	output logic                          ram_wdata,
	output logic                          ram_re,
	output logic [IW-1:0]                 ram_raddr,
	input  logic                          ram_rdata,
	output logic                          predicted_taken,
	output logic [obbp_pkg::CNT_W-1:0]    total_count,
	output logic [obbp_pkg::CNT_W-1:0]    taken_count,
	output logic [obbp_pkg::CNT_W-1:0]    correct_count,
	output logic [obbp_pkg::CNT_W-1:0]    correct_taken_count,
	output logic [obbp_pkg::CNT_W-1:0]    correct_not_taken_count
);
	import obbp_pkg::*;

	localparam int RECIP = (1 << RECIP_SHIFT) / TABLE_DEPTH;
	localparam logic [31:0] DEPTH_32 = 32'(TABLE_DEPTH);

	req_t                  req_q;
	logic                  actual_q;
	logic [FOLD_W-1:0]     masked_q;
	logic [RECIP_SHIFT-1:0] quot_q;
	logic [IW-1:0]         idx_q;
	logic [IW-1:0]         sweep_q;
	logic                  pred_q;
	logic [CNT_W-1:0]      total_q, taken_q, correct_q, corr_tk_q, corr_nt_q;

	logic [ADDR_W-1:0] folded;
	logic [15:0]       mask;
	logic [31:0]       recip_prod;
	logic [31:0]       back_prod, rem_raw, rem_fix;
	logic              is_update;

	// hash: fold the shifted address, keep the index_bits low bits
	assign folded = branch_address ^ (branch_address >> fold_shift);
	assign mask   = (16'd1 << index_bits) - 16'd1;

	// modulo TABLE_DEPTH by reciprocal; estimate is exact or one low
	assign recip_prod = 32'(masked_q) * 32'(RECIP);
	assign back_prod  = 32'(quot_q) * DEPTH_32;
	assign rem_raw    = 32'(masked_q) - back_prod;
	assign rem_fix    = (rem_raw >= DEPTH_32) ? rem_raw - DEPTH_32 : rem_raw;

	assign is_update = (req_q == REQ_UPDATE);

	assign ram_re    = cmd.lookup;
	assign ram_raddr = rem_fix[IW-1:0];
	assign ram_we    = cmd.sweep || (cmd.commit && is_update);
	assign ram_waddr = cmd.sweep ? sweep_q : idx_q;
	assign ram_wdata = cmd.sweep ? 1'b0 : actual_q;

	assign sts.clear_all  = (req_q == REQ_CLEAR_ALL);
	assign sts.sweep_last = (sweep_q == IW'(TABLE_DEPTH - 1));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q    <= req_t'(req_type);
			actual_q <= actual_taken;
			masked_q <= folded[FOLD_W-1:0] & mask[FOLD_W-1:0];
		end
		if (cmd.divide) begin
			quot_q <= recip_prod[31 -: RECIP_SHIFT];
		end
		if (cmd.lookup) begin
			idx_q <= rem_fix[IW-1:0];
		end
		if (cmd.commit) begin
			pred_q <= ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q   <= '0;
			total_q   <= '0;
			taken_q   <= '0;
			correct_q <= '0;
			corr_tk_q <= '0;
			corr_nt_q <= '0;
		end else begin
			if (cmd.sweep) begin
				sweep_q <= sts.sweep_last ? '0 : sweep_q + IW'(1);
			end
			if (cmd.commit) begin
				case (req_q)
					REQ_UPDATE: begin
						total_q <= sat_inc(total_q);
						if (actual_q) begin
							taken_q <= sat_inc(taken_q);
						end
						if (ram_rdata == actual_q) begin
							correct_q <= sat_inc(correct_q);
						end
						if (actual_q && ram_rdata) begin
							corr_tk_q <= sat_inc(corr_tk_q);
						end
						if (!actual_q && !ram_rdata) begin
							corr_nt_q <= sat_inc(corr_nt_q);
						end
					end
					REQ_CLEAR_STATS, REQ_CLEAR_ALL: begin
						total_q   <= '0;
						taken_q   <= '0;
						correct_q <= '0;
						corr_tk_q <= '0;
						corr_nt_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// counters only move on commit, so they double as the result register
	assign predicted_taken         = pred_q;
	assign total_count             = total_q;
	assign taken_count             = taken_q;
	assign correct_count           = correct_q;
	assign correct_taken_count     = corr_tk_q;
	assign correct_not_taken_count = corr_nt_q;

endmodule

>>> verif/obbp_checker.sv
// obbp_checker: watches the req, rsp and APB ports of the branch predictor, predicts each rsp word
// and compares it field by field. Depends on obbp_pkg and obbp_ifs.
`timescale 1ns / 1ps

module obbp_checker #(
	parameter int TABLE_DEPTH = obbp_pkg::TABLE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	obbp_req_if                          req,
	obbp_rsp_if                          rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [obbp_pkg::PADDR_W-1:0] paddr,
	input  logic [obbp_pkg::DATA_W-1:0]  pwdata,
	input  logic                         pready,
	output int                           pending,
	output int                           fail_count
);
	import obbp_pkg::*;

	localparam int PRINT_MAX = 40;

	typedef struct packed {
		logic [CNT_W-1:0] total;
		logic [CNT_W-1:0] taken;
		logic [CNT_W-1:0] hit;
		logic [CNT_W-1:0] hit_taken;
		logic [CNT_W-1:0] hit_not_taken;
	} tally_t;

	typedef struct packed {
		logic   guess;
		tally_t tally;
	} verdict_t;

	logic [TABLE_DEPTH-1:0] dir_bits;
	tally_t                 stats;
	logic [3:0]             idx_bits_cfg;
	logic [5:0]             shift_cfg;
	verdict_t               verdict_q[$];
	int                     words_seen;

	task automatic report(input string what, input logic [CNT_W-1:0] want,
		input logic [CNT_W-1:0] got);
		fail_count++;
		if (fail_count <= PRINT_MAX)
			$display("obbp_checker: word %0d %s: expected %0d, got %0d",
				words_seen, what, want, got);
	endtask

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

	// hash: pc ^ (pc >> shift), masked to index_bits, wrapped onto the table
	function automatic int fold_index(input logic [ADDR_W-1:0] pc);
		logic [ADDR_W-1:0] folded;
		logic [ADDR_W-1:0] mask;
		folded = pc ^ (pc >> shift_cfg);
		mask   = (64'd1 << idx_bits_cfg) - 64'd1;
		return int'((folded & mask) % TABLE_DEPTH);
	endfunction

	task automatic resolve_branch(input req_t kind, input logic [ADDR_W-1:0] pc,
		input logic outcome, output verdict_t res);
		int   slot;
		logic guess;
		slot  = fold_index(pc);
		guess = dir_bits[slot];
		case (kind)
			REQ_UPDATE: begin
				stats.total = bump(stats.total);
				if (outcome) begin
					stats.taken = bump(stats.taken);
					if (guess)
						stats.hit_taken = bump(stats.hit_taken);
				end else if (!guess) begin
					stats.hit_not_taken = bump(stats.hit_not_taken);
				end
				if (guess == outcome)
					stats.hit = bump(stats.hit);
				dir_bits[slot] = outcome;
			end
			REQ_CLEAR_STATS: stats = '0;
			REQ_CLEAR_ALL: begin
				stats    = '0;
				dir_bits = '0;
			end
			default: ;
		endcase
		res.guess = guess;
		res.tally = stats;
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		verdict_t got;
		if (!arst_n) begin
			dir_bits     = '0;
			stats        = '0;
			idx_bits_cfg = INDEX_BITS_RST;
			shift_cfg    = FOLD_SHIFT_RST;
			verdict_q.delete();
			words_seen   = 0;
			fail_count   = 0;
		end else begin
			// register write completes at the access edge; byte address 4*i
			if (psel && penable && pwrite && pready) begin
				case (reg_t'(paddr[2]))
					REG_INDEX_BITS: idx_bits_cfg = pwdata[3:0];
					REG_FOLD_SHIFT: shift_cfg    = pwdata[5:0];
					default: ;
				endcase
			end
			// result side first: a word accepted this edge cannot belong to a new request
			if (rsp.valid && rsp.ready) begin
				words_seen++;
				got.guess               = rsp.predicted_taken;
				got.tally.total         = rsp.total_count;
				got.tally.taken         = rsp.taken_count;
				got.tally.hit           = rsp.correct_count;
				got.tally.hit_taken     = rsp.correct_taken_count;
				got.tally.hit_not_taken = rsp.correct_not_taken_count;
				if (verdict_q.size() == 0) begin
					report("rsp word with no request outstanding", '0, '0);
				end else begin
					want = verdict_q.pop_front();
					if (got.guess !== want.guess)
						report("predicted_taken", want.guess, got.guess);
					if (got.tally.total !== want.tally.total)
						report("total_count", want.tally.total, got.tally.total);
					if (got.tally.taken !== want.tally.taken)
						report("taken_count", want.tally.taken, got.tally.taken);
					if (got.tally.hit !== want.tally.hit)
						report("correct_count", want.tally.hit, got.tally.hit);
					if (got.tally.hit_taken !== want.tally.hit_taken)
						report("correct_taken_count", want.tally.hit_taken,
							got.tally.hit_taken);
					if (got.tally.hit_not_taken !== want.tally.hit_not_taken)
						report("correct_not_taken_count", want.tally.hit_not_taken,
							got.tally.hit_not_taken);
				end
			end
			if (req.valid && req.ready) begin
				resolve_branch(req_t'(req.req_type), req.branch_address, req.actual_taken, want);
				verdict_q.push_back(want);
			end
		end
		pending = verdict_q.size();
	end

endmodule

>>> verif/testbench.sv
// testbench: drives requests and register writes into one_bit_branch_predictor and gives the verdict.
// Depends on obbp_pkg, obbp_ifs, the predictor RTL and obbp_checker.
`timescale 1ns / 1ps

module testbench;
	import obbp_pkg::*;

	localparam int DEPTH           = TABLE_DEPTH_DEF;
	// clear-all sweeps the whole table, possibly after its word is out
	localparam int SETTLE_CYCLES   = DEPTH + 16;
	localparam int HOLD_CYCLES     = 300;
	localparam int PHASES          = 9;
	localparam int WORDS_PER_PHASE = 64;
	localparam int HOT_BRANCHES    = 16;
	// watchdog limit on the whole run; leave lots of margin over the slowest run
	localparam int CYCLE_LIMIT     = 600000;

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [DATA_W-1:0]  pwdata  = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	int unsigned send_idle_pct = 25;
	int unsigned recv_idle_pct = 63;
	logic        holding       = 1'b0;
	int unsigned cycle_count   = 0;
	int          pending;
	int          fail_count;
	event        hold_kick;

	// register settings per phase: extremes of both fields, zero shift, index past the table
	int unsigned phase_index_bits[PHASES] = '{10, 0, 15, 4, 11, 10, 1, 13, 7};
	int unsigned phase_shift[PHASES]      = '{12, 0, 63, 1, 5, 0, 63, 32, 20};

	obbp_req_if req_ch();
	obbp_rsp_if rsp_ch();

	one_bit_branch_predictor #(.TABLE_DEPTH(DEPTH)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	obbp_checker #(.TABLE_DEPTH(DEPTH)) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pready    (pready),
		.pending   (pending),
		.fail_count(fail_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// long rsp stall: holding flips only at rising edges, read at falling edges
	initial forever begin
		@(hold_kick);
		@(posedge clk);
		holding = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		holding = 1'b0;
	end

	// rsp ready: random back-pressure, or held low during a long stall
	always @(negedge clk) begin
		if (holding)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// offer one request word; called and returns at a falling edge.
	// valid stays high into the next word unless a gap is drawn.
	task automatic send_word(input req_t kind, input logic [ADDR_W-1:0] pc, input logic outcome);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid          <= 1'b0;
			req_ch.req_type       <= 2'($urandom_range(3));
			req_ch.branch_address <= {$urandom, $urandom};
			req_ch.actual_taken   <= 1'($urandom_range(1));
			@(negedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.req_type       <= kind;
		req_ch.branch_address <= pc;
		req_ch.actual_taken   <= outcome;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// APB write: setup, access, then idle, so back-to-back writes never collide
	task automatic write_reg(input reg_t which, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {which, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// field value in the low bits, junk above (the registers take only their own width)
	task automatic configure(input int unsigned ibits, input int unsigned shift);
		write_reg(REG_INDEX_BITS, {$urandom} & ~32'hf | (ibits & 32'hf));
		write_reg(REG_FOLD_SHIFT, {$urandom} & ~32'h3f | (shift & 32'h3f));
	endtask

	// stop offering, wait out every outstanding word plus any trailing table sweep
	task automatic settle();
		req_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// mostly a small pool of hot branches with a strong bias each, so the table
	// actually learns; the rest is random pcs and random outcomes
	task automatic send_random(input int count);
		logic [ADDR_W-1:0] hot_pc[HOT_BRANCHES];
		int unsigned       hot_bias[HOT_BRANCHES];
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] pc;
		logic              outcome;
		req_t              kind;
		int unsigned       roll;
		int unsigned       pick;
		base = {$urandom, $urandom};
		for (int i = 0; i < HOT_BRANCHES; i++) begin
			hot_pc[i]   = ($urandom_range(3) != 0)
				? base + ADDR_W'(4 * $urandom_range(4095))
				: {$urandom, $urandom};
			hot_bias[i] = $urandom_range(1) ? 92 : 8;
		end
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll < 47)
				kind = REQ_UPDATE;
			else if (roll < 89)
				kind = REQ_PREDICT;
			else if (roll < 97)
				kind = REQ_CLEAR_STATS;
			else
				kind = REQ_CLEAR_ALL;
			if ($urandom_range(3) != 0) begin
				pick    = $urandom_range(HOT_BRANCHES - 1);
				pc      = hot_pc[pick];
				outcome = ($urandom_range(99) < hot_bias[pick]);
			end else begin
				pc      = {$urandom, $urandom};
				outcome = 1'($urandom_range(1));
			end
			send_word(kind, pc, outcome);
		end
	endtask

	initial begin
		logic [ADDR_W-1:0] pc_zero;
		logic [ADDR_W-1:0] pc_ones;
		logic [ADDR_W-1:0] pc_msb;
		logic [ADDR_W-1:0] pc_even;
		logic [ADDR_W-1:0] pc_odd;
		pc_zero = '0;
		pc_ones = '1;
		pc_msb  = 64'h8000_0000_0000_0000;
		pc_even = 64'h5555_5555_5555_5555;
		pc_odd  = 64'haaaa_aaaa_aaaa_aaaa;

		req_ch.valid          = 1'b0;
		req_ch.req_type       = REQ_PREDICT;
		req_ch.branch_address = '0;
		req_ch.actual_taken   = 1'b0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// table clear runs after reset; requests would just wait, but keep writes clean
		repeat (SETTLE_CYCLES) @(negedge clk);

		// directed words at reset settings: learn, mispredict both ways, clears
		send_word(REQ_PREDICT, pc_zero, 1'b0);
		send_word(REQ_UPDATE, pc_zero, 1'b1);
		send_word(REQ_PREDICT, pc_zero, 1'b1);
		send_word(REQ_UPDATE, pc_zero, 1'b1);
		send_word(REQ_UPDATE, pc_zero, 1'b0);
		send_word(REQ_UPDATE, pc_zero, 1'b0);
		send_word(REQ_UPDATE, pc_ones, 1'b1);
		send_word(REQ_UPDATE, pc_ones, 1'b1);
		send_word(REQ_PREDICT, pc_ones, 1'b0);
		// clear-stats still reports the stored bit; outcome bit is ignored
		send_word(REQ_CLEAR_STATS, pc_ones, 1'b1);
		send_word(REQ_UPDATE, pc_msb, 1'b1);
		send_word(REQ_UPDATE, pc_even, 1'b0);
		send_word(REQ_UPDATE, pc_odd, 1'b1);
		send_word(REQ_PREDICT, pc_odd, 1'b0);
		// clear-all reports the old bit, then the table reads back empty
		send_word(REQ_CLEAR_ALL, pc_odd, 1'b0);
		send_word(REQ_PREDICT, pc_odd, 1'b1);
		send_word(REQ_PREDICT, pc_ones, 1'b0);
		send_word(REQ_UPDATE, pc_even, 1'b1);
		send_word(REQ_PREDICT, pc_msb, 1'b0);
		send_word(REQ_CLEAR_STATS, pc_zero, 1'b0);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			// idling: sender light / receiver heavy, then swapped, then none
			if (p == 3) begin
				send_idle_pct = 63;
				recv_idle_pct = 25;
			end else if (p == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			configure(phase_index_bits[p], phase_shift[p]);
			// receiver stalls long while requests keep coming: input backs up
			if (p == 1 || p == 7)
				-> hold_kick;
			send_random(WORDS_PER_PHASE);
			settle();
		end

		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
